@@ design/assert_macros.svh @@
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ddr3mr_pkg.sv @@
`timescale 1ns / 1ps

package ddr3mr_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DIMM_TYPE       = 3'd0,
        CFG_BOARD_KIND      = 3'd1,
        CFG_DIMMS_POPULATED = 3'd2,
        CFG_RANK_COUNTS     = 3'd3,
        CFG_FREQ_INDEX      = 3'd4,
        CFG_TIMING_WORD     = 3'd5,
        CFG_MODE_BITS       = 3'd6,
        CFG_PRESENCE_MASKS  = 3'd7
    } t_cfg_idx;

    // Mode register selected by a request.
    typedef enum logic [1:0] {
        MR0 = 2'd0,
        MR1 = 2'd1,
        MR2 = 2'd2,
        MR3 = 2'd3
    } t_mr_cmd;

    localparam int CFG_DATA_W = 24;
    localparam int WORD_W     = 24;

    // DIMM type codes.
    localparam logic [1:0] DIMM_UNBUF = 2'd0;
    localparam logic [1:0] DIMM_REG   = 2'd1;
    localparam logic [1:0] DIMM_LR    = 2'd2;

    // Memory clock codes.
    localparam logic [4:0] FREQ_667  = 5'h04;
    localparam logic [4:0] FREQ_800  = 5'h06;
    localparam logic [4:0] FREQ_1066 = 5'h0a;
    localparam logic [4:0] FREQ_1333 = 5'h0e;
    localparam logic [4:0] FREQ_1600 = 5'h12;

    // Bank address patterns and mirroring constants.
    localparam logic [WORD_W-1:0] C_BA_MR1      = 24'h040000;
    localparam logic [WORD_W-1:0] C_BA_MR2      = 24'h080000;
    localparam logic [WORD_W-1:0] C_BA_MR3      = 24'h0c0000;
    localparam logic [WORD_W-1:0] C_MIRROR_BITS = 24'h0c01f8;
    localparam logic [7:0]        C_EVEN_MASK   = 8'h55;
    localparam logic [7:0]        C_ODD_MASK    = 8'haa;

    // Configuration register file.
    typedef struct packed {
        logic [1:0]  dimm_type;
        logic [1:0]  board_kind;
        logic [1:0]  dimms_populated;
        logic [11:0] rank_counts;
        logic [4:0]  freq_index;
        logic [14:0] timing_word;
        logic [3:0]  mode_bits;
        logic [23:0] presence_masks;
    } t_cfg;

    // Rank count of one DIMM slot.
    function automatic logic [2:0] f_ranks_of(input t_cfg c, input logic [1:0] d);
        logic [2:0] r;
        case (d)
            2'd0:    r = c.rank_counts[2:0];
            2'd1:    r = c.rank_counts[5:3];
            2'd2:    r = c.rank_counts[8:6];
            default: r = c.rank_counts[11:9];
        endcase
        return r;
    endfunction

    // Write recovery code for MR0.
    function automatic logic [2:0] f_wr_code(input logic [4:0] twr);
        logic [2:0] r;
        case (twr)
            5'h05:   r = 3'd1;
            5'h06:   r = 3'd2;
            5'h07:   r = 3'd3;
            5'h08:   r = 3'd4;
            5'h0a:   r = 3'd5;
            5'h0c:   r = 3'd6;
            5'h0e:   r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // CAS latency code for MR0; the low bit lands in A2.
    function automatic logic [3:0] f_cl_code(input logic [4:0] tcl);
        logic [3:0] r;
        case (tcl)
            5'h05:   r = 4'd2;
            5'h06:   r = 4'd4;
            5'h07:   r = 4'd6;
            5'h08:   r = 4'd8;
            5'h09:   r = 4'd10;
            5'h0a:   r = 4'd12;
            5'h0b:   r = 4'd14;
            5'h0c:   r = 4'd1;
            5'h0d:   r = 4'd3;
            5'h0e:   r = 4'd5;
            5'h0f:   r = 4'd7;
            5'h10:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Registered DIMM, two slots: nominal termination by population.
    function automatic logic [2:0] f_nom_reg_two(input t_cfg c, input logic rank,
                                                 input logic [2:0] one_val);
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] t;
        a = f_ranks_of(c, 2'd0);
        b = f_ranks_of(c, 2'd1);
        t = 3'd0;
        if (c.dimms_populated == 2'd1) begin
            if (a < 3'd4 && b < 3'd4) return one_val;
            return rank ? 3'd0 : one_val;
        end
        if (a < 3'd4 && b < 3'd4) return 3'd3;
        if (a == 3'd4) begin
            t = (b == 3'd1) ? 3'd5 : 3'd1;
        end else if (b == 3'd4) begin
            t = (a == 3'd1) ? 3'd5 : 3'd1;
        end
        if (rank) t = 3'd0;
        return t;
    endfunction

    // Nominal ODT value for MR1.
    function automatic logic [2:0] f_rtt_nom(input t_cfg c, input logic rank);
        logic [4:0] f;
        logic [1:0] nd;
        logic [1:0] mx;
        logic [2:0] a;
        logic [2:0] b;
        f  = c.freq_index;
        nd = c.dimms_populated;
        mx = c.board_kind;
        a  = f_ranks_of(c, 2'd0);
        b  = f_ranks_of(c, 2'd1);
        if (c.dimm_type == DIMM_LR || mx == 2'd0) return 3'd0;
        if (c.dimm_type == DIMM_REG) begin
            if (mx == 2'd1) begin
                if (f == FREQ_667 || f == FREQ_800) return (a < 3'd4 || !rank) ? 3'd2 : 3'd0;
                if (f == FREQ_1066) return 3'd1;
                if (f == FREQ_1333) return (a < 3'd4) ? 3'd1 : (rank ? 3'd0 : 3'd3);
                return 3'd3;
            end
            if (mx == 2'd2) begin
                if (f == FREQ_667 || f == FREQ_800) return f_nom_reg_two(c, rank, 3'd2);
                if (f == FREQ_1066) return f_nom_reg_two(c, rank, 3'd1);
                if (f == FREQ_1333) begin
                    if (nd != 2'd1) return 3'd5;
                    if (a < 3'd4 && b < 3'd4) return 3'd1;
                    return rank ? 3'd0 : 3'd3;
                end
                return (nd == 2'd1) ? 3'd3 : 3'd4;
            end
            return 3'd0;
        end
        if (mx == 2'd1) begin
            if (f == FREQ_667 || f == FREQ_800) return 3'd2;
            if (f == FREQ_1066 || f == FREQ_1333) return 3'd1;
            return 3'd3;
        end
        if (mx == 2'd2) begin
            if (nd == 2'd1) begin
                return (f <= FREQ_800) ? 3'd2 : (f <= FREQ_1333) ? 3'd1 : 3'd3;
            end
            return (f <= FREQ_1066) ? 3'd3 : (f <= FREQ_1333) ? 3'd5 : 3'd4;
        end
        if (nd == 2'd2) begin
            if (f <= FREQ_1066) return rank ? 3'd0 : 3'd3;
            if (f <= FREQ_1333) return rank ? 3'd0 : 3'd5;
        end
        return 3'd0;
    endfunction

    // Dynamic ODT value for MR2.
    function automatic logic [1:0] f_rtt_wr(input t_cfg c, input logic [1:0] dimm);
        logic [4:0] f;
        logic [1:0] nd;
        logic [1:0] mx;
        logic [2:0] rc;
        logic [2:0] a;
        logic [2:0] b;
        f  = c.freq_index;
        nd = c.dimms_populated;
        mx = c.board_kind;
        rc = f_ranks_of(c, dimm);
        a  = f_ranks_of(c, 2'd0);
        b  = f_ranks_of(c, 2'd1);
        if (c.dimm_type == DIMM_LR || mx == 2'd0) return 2'd0;
        if (c.dimm_type == DIMM_REG) begin
            if (mx == 2'd1) begin
                if (f == FREQ_667 || f == FREQ_800 || f == FREQ_1066 || f == FREQ_1333)
                    return (rc < 3'd3) ? 2'd0 : 2'd2;
                return 2'd0;
            end
            if (mx == 2'd2) begin
                if (f == FREQ_667 || f == FREQ_800)
                    return (nd == 2'd1 && a < 3'd4 && b < 3'd4) ? 2'd0 : 2'd2;
                if (f == FREQ_1066) begin
                    if (nd == 2'd1) return (a < 3'd4 && b < 3'd4) ? 2'd0 : 2'd2;
                    return 2'd1;
                end
                if (f == FREQ_1333) return 2'd2;
                return (nd == 2'd1) ? 2'd0 : 2'd1;
            end
            if (f == FREQ_1066 || f == FREQ_1333)
                return (f_ranks_of(c, 2'd2) < 3'd4) ? 2'd1 : 2'd2;
            if (f == FREQ_1600) return 2'd1;
            return 2'd2;
        end
        if (mx == 2'd1) return 2'd0;
        if (mx == 2'd2) begin
            if (nd == 2'd2 && f == FREQ_1600) return 2'd1;
            if (nd == 2'd1) return 2'd0;
            return 2'd2;
        end
        if (nd == 2'd1) begin
            if (f <= FREQ_1066) return 2'd2;
            return (rc < 3'd3) ? 2'd1 : 2'd2;
        end
        if (nd == 2'd2) return 2'd2;
        return 2'd0;
    endfunction

endpackage

@@ design/ddr3_mode_register_word_gen.sv @@
`timescale 1ns / 1ps

// DDR3 MRS word generator: each request names a mode register (MR0..MR3, in
// s_axis_tuser) and a chip select (in s_axis_tdata) and yields the 24-bit
// MRS address word, with chip select at bits 23:21 and bank address at
// 19:18, after address mirroring for mirrored ranks on unbuffered DIMMs.
// The block takes one request per clock while the result side keeps up. A
// request is captured in an input register at the edge that accepts it. The
// table lookups and bit packing between that register and the result register
// are combinational. The word is loaded into the result register once that
// register is free, and m_axis presents it from there.
// Back-pressure on the result side stalls the input side only once both
// registers hold data. Configuration is written through i_cfg_we /
// i_cfg_addr / i_cfg_wdata and must only change while no request is in
// flight.
`include "assert_macros.svh"

module ddr3_mode_register_word_gen (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_addr,
    input  logic [ddr3mr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [2:0] chip_select
    input  logic [1:0]                        s_axis_tuser,  // [1:0] cmd
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // [23:0] mrs_word
    output logic                              m_axis_tuser   // [0] was_mirrored
);
    import ddr3mr_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_mr_cmd           r_in_cmd;
    logic [2:0]        r_in_cs;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_mirr;

    logic              w_adv_out;
    logic              w_adv_in;
    logic [1:0]        w_dimm;
    logic              w_rank;
    logic [3:0]        w_cl;
    logic [2:0]        w_nom;
    logic [7:0]        w_x8;
    logic [7:0]        w_x4;
    logic [7:0]        w_other;
    logic [7:0]        w_mirror_mask;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_swapped;
    logic              w_mirror_on;
    logic [WORD_W-1:0] n_out_word;

    // Pipeline advance: the result register frees up when empty or taken.
    assign w_adv_out     = !r_out_valid || m_axis_tready;
    assign w_adv_in      = !r_in_valid || w_adv_out;
    assign s_axis_tready = w_adv_in;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimm_type       <= DIMM_UNBUF;
            r_cfg.board_kind      <= 2'd1;
            r_cfg.dimms_populated <= 2'd1;
            r_cfg.rank_counts     <= '0;
            r_cfg.freq_index      <= FREQ_667;
            r_cfg.timing_word     <= '0;
            r_cfg.mode_bits       <= '0;
            r_cfg.presence_masks  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DIMM_TYPE:       r_cfg.dimm_type       <= i_cfg_wdata[1:0];
                CFG_BOARD_KIND:      r_cfg.board_kind      <= i_cfg_wdata[1:0];
                CFG_DIMMS_POPULATED: r_cfg.dimms_populated <= i_cfg_wdata[1:0];
                CFG_RANK_COUNTS:     r_cfg.rank_counts     <= i_cfg_wdata[11:0];
                CFG_FREQ_INDEX:      r_cfg.freq_index      <= i_cfg_wdata[4:0];
                CFG_TIMING_WORD:     r_cfg.timing_word     <= i_cfg_wdata[14:0];
                CFG_MODE_BITS:       r_cfg.mode_bits       <= i_cfg_wdata[3:0];
                CFG_PRESENCE_MASKS:  r_cfg.presence_masks  <= i_cfg_wdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv_in) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in && s_axis_tvalid) begin
            r_in_cmd <= t_mr_cmd'(s_axis_tuser);
            r_in_cs  <= s_axis_tdata[2:0];
        end
    end

    // Word assembly for the registered request.
    assign w_dimm  = r_in_cs[2:1];
    assign w_rank  = r_in_cs[0];
    assign w_cl    = f_cl_code(r_cfg.timing_word[4:0]);
    assign w_nom   = f_rtt_nom(r_cfg, w_rank);
    assign w_x8    = r_cfg.presence_masks[7:0];
    assign w_x4    = r_cfg.presence_masks[15:8];
    assign w_other = w_dimm[0] ? (w_x4 & C_EVEN_MASK) : (w_x4 & C_ODD_MASK);

    always_comb begin
        w_word = {r_in_cs, 21'd0};
        case (r_in_cmd)
            MR0: begin
                w_word[12]   = r_cfg.mode_bits[2];
                w_word[11:9] = f_wr_code(r_cfg.timing_word[9:5]);
                w_word[8]    = 1'b1;
                w_word[6:4]  = w_cl[3:1];
                w_word[3]    = 1'b1;
                w_word[2]    = w_cl[0];
                w_word[1:0]  = r_cfg.mode_bits[1:0];
            end
            MR1: begin
                w_word     = w_word | C_BA_MR1;
                w_word[11] = w_x8[w_dimm] && (w_other != 8'd0) &&
                             (r_cfg.dimm_type == DIMM_LR);
                w_word[9]  = w_nom[2];
                w_word[6]  = w_nom[1];
                w_word[2]  = w_nom[0];
                w_word[1]  = (r_cfg.dimm_type != DIMM_LR);
            end
            MR2: begin
                w_word       = w_word | C_BA_MR2;
                w_word[10:9] = f_rtt_wr(r_cfg, w_dimm);
                w_word[7]    = 1'b1;
                w_word[5:3]  = r_cfg.timing_word[12:10] - 3'd5;
            end
            MR3: begin
                w_word = w_word | C_BA_MR3;
            end
            default: begin
            end
        endcase
    end

    // Address mirroring: odd chip selects of the active channel on unbuffered DIMMs.
    always_comb begin
        if (r_cfg.mode_bits[3]) begin
            w_mirror_mask = r_cfg.presence_masks[23:16] & C_ODD_MASK;
        end else begin
            w_mirror_mask = {r_cfg.presence_masks[22:16] & C_EVEN_MASK[6:0], 1'b0};
        end
        w_mirror_on = (r_cfg.dimm_type != DIMM_REG) && (r_cfg.dimm_type != DIMM_LR) &&
                      w_mirror_mask[r_in_cs];
        w_swapped     = w_word & ~C_MIRROR_BITS;
        w_swapped[3]  = w_word[4];
        w_swapped[4]  = w_word[3];
        w_swapped[5]  = w_word[6];
        w_swapped[6]  = w_word[5];
        w_swapped[7]  = w_word[8];
        w_swapped[8]  = w_word[7];
        w_swapped[18] = w_word[19];
        w_swapped[19] = w_word[18];
        n_out_word    = w_mirror_on ? w_swapped : w_word;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_in_valid) begin
            r_out_word <= n_out_word;
            r_out_mirr <= w_mirror_on;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_mirr;

    // Checks.
    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready,
        r_in_valid && r_out_valid && !m_axis_tready, "input stalled with room free")
    `ASSERT_NEXT(a_in_moves_out, i_clk, i_rst_n, r_in_valid && w_adv_out,
        r_out_valid, "request lost between input and result register")
    `ASSERT_IMPL(a_mirror_odd_cs, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[21], "mirroring applied to an even chip select")
    `ASSERT_IMPL(a_mirror_unbuf, i_clk, i_rst_n, r_in_valid && w_mirror_on,
        r_cfg.dimm_type != DIMM_REG && r_cfg.dimm_type != DIMM_LR,
        "mirroring applied to a buffered DIMM")

endmodule

@@ tb/tb_ddr3_mode_register_word_gen.sv @@
`timescale 1ns / 1ps

module tb_ddr3_mode_register_word_gen;
    import ddr3mr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_PHASES = 30;
    localparam int PHASE_ITEMS   = 50;

    // Expected MRS word together with the request that produced it.
    typedef struct {
        t_mr_cmd     cmd;
        logic [2:0]  cs;
        logic [23:0] word;
        logic        mirrored;
    } t_mrs_result;

    // Local copy of the configuration registers.
    typedef struct {
        logic [1:0]  dimm_type;
        logic [1:0]  board_kind;
        logic [1:0]  dimms_populated;
        logic [11:0] rank_counts;
        logic [4:0]  freq_index;
        logic [14:0] timing_word;
        logic [3:0]  mode_bits;
        logic [23:0] presence_masks;
    } t_shadow_cfg;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [23:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [2:0] chip_select
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [23:0] mrs_word
    logic        m_axis_tuser;   // [0] was_mirrored

    t_shadow_cfg shadow;
    t_mrs_result expected_results[$];
    int          error_count;
    int          cycle_count;
    int          hold_off_cycles;
    bit          full_rate;

    ddr3_mode_register_word_gen u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Cycle counter that ends a hung run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Rank count of one DIMM slot.
    function automatic logic [2:0] ranks_on(input logic [1:0] slot);
        return shadow.rank_counts[3 * slot +: 3];
    endfunction

    // Write recovery encoding; unlisted values give zero.
    function automatic logic [2:0] wr_encode(input logic [4:0] twr);
        case (twr)
            5'd5:    return 3'd1;
            5'd6:    return 3'd2;
            5'd7:    return 3'd3;
            5'd8:    return 3'd4;
            5'd10:   return 3'd5;
            5'd12:   return 3'd6;
            5'd14:   return 3'd7;
            default: return 3'd0;
        endcase
    endfunction

    // CAS latency encoding: the shorter listed latencies give even codes, the longer ones odd codes.
    function automatic logic [3:0] cl_encode(input logic [4:0] tcl);
        int t;
        t = tcl;
        if (t >= 5 && t <= 11) return 4'((t - 4) * 2);
        if (t >= 12 && t <= 16) return 4'((t - 12) * 2 + 1);
        return 4'd0;
    endfunction

    // Registered DIMMs on a two-slot board: termination by population.
    function automatic logic [2:0] reg_two_slot_nom(input logic rank,
                                                    input logic [2:0] single_val);
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] val;
        a = ranks_on(2'd0);
        b = ranks_on(2'd1);
        val = 3'd0;
        if (shadow.dimms_populated == 2'd1) begin
            return ((a < 3'd4 && b < 3'd4) || !rank) ? single_val : 3'd0;
        end
        if (a < 3'd4 && b < 3'd4) return 3'd3;
        if (a == 3'd4) begin
            val = (b == 3'd1) ? 3'd5 : 3'd1;
        end else if (b == 3'd4) begin
            val = (a == 3'd1) ? 3'd5 : 3'd1;
        end
        return rank ? 3'd0 : val;
    endfunction

    // Nominal on-die termination carried in MR1.
    function automatic logic [2:0] nominal_odt(input logic rank);
        logic [4:0] f;
        logic [1:0] nd;
        logic [1:0] bk;
        logic [2:0] a;
        logic [2:0] b;
        f  = shadow.freq_index;
        nd = shadow.dimms_populated;
        bk = shadow.board_kind;
        a  = ranks_on(2'd0);
        b  = ranks_on(2'd1);
        if (shadow.dimm_type == DIMM_LR || bk == 2'd0) return 3'd0;
        if (shadow.dimm_type == DIMM_REG) begin
            if (bk == 2'd1) begin
                if (f == FREQ_667 || f == FREQ_800) return (a < 3'd4 || !rank) ? 3'd2 : 3'd0;
                if (f == FREQ_1066) return 3'd1;
                if (f == FREQ_1333) return (a < 3'd4) ? 3'd1 : (rank ? 3'd0 : 3'd3);
                return 3'd3;
            end
            if (bk == 2'd2) begin
                if (f == FREQ_667 || f == FREQ_800) return reg_two_slot_nom(rank, 3'd2);
                if (f == FREQ_1066) return reg_two_slot_nom(rank, 3'd1);
                if (f == FREQ_1333) begin
                    if (nd != 2'd1) return 3'd5;
                    if (a < 3'd4 && b < 3'd4) return 3'd1;
                    return rank ? 3'd0 : 3'd3;
                end
                return (nd == 2'd1) ? 3'd3 : 3'd4;
            end
            return 3'd0;
        end
        // Unbuffered, and the unknown type treated the same way.
        if (bk == 2'd1) begin
            if (f == FREQ_667 || f == FREQ_800) return 3'd2;
            if (f == FREQ_1066 || f == FREQ_1333) return 3'd1;
            return 3'd3;
        end
        if (bk == 2'd2) begin
            if (nd == 2'd1) return (f <= FREQ_800) ? 3'd2 : (f <= FREQ_1333) ? 3'd1 : 3'd3;
            return (f <= FREQ_1066) ? 3'd3 : (f <= FREQ_1333) ? 3'd5 : 3'd4;
        end
        if (nd == 2'd2) begin
            if (f <= FREQ_1066) return rank ? 3'd0 : 3'd3;
            if (f <= FREQ_1333) return rank ? 3'd0 : 3'd5;
        end
        return 3'd0;
    endfunction

    // Dynamic on-die termination carried in MR2.
    function automatic logic [1:0] write_odt(input logic [1:0] slot);
        logic [4:0] f;
        logic [1:0] nd;
        logic [1:0] bk;
        logic [2:0] rc;
        logic       both_small;
        f  = shadow.freq_index;
        nd = shadow.dimms_populated;
        bk = shadow.board_kind;
        rc = ranks_on(slot);
        both_small = (ranks_on(2'd0) < 3'd4) && (ranks_on(2'd1) < 3'd4);
        if (shadow.dimm_type == DIMM_LR || bk == 2'd0) return 2'd0;
        if (shadow.dimm_type == DIMM_REG) begin
            if (bk == 2'd1) begin
                if (f == FREQ_667 || f == FREQ_800 || f == FREQ_1066 || f == FREQ_1333)
                    return (rc < 3'd3) ? 2'd0 : 2'd2;
                return 2'd0;
            end
            if (bk == 2'd2) begin
                if (f == FREQ_667 || f == FREQ_800)
                    return (nd == 2'd1 && both_small) ? 2'd0 : 2'd2;
                if (f == FREQ_1066) begin
                    if (nd == 2'd1) return both_small ? 2'd0 : 2'd2;
                    return 2'd1;
                end
                if (f == FREQ_1333) return 2'd2;
                return (nd == 2'd1) ? 2'd0 : 2'd1;
            end
            if (f == FREQ_1066 || f == FREQ_1333) return (ranks_on(2'd2) < 3'd4) ? 2'd1 : 2'd2;
            if (f == FREQ_1600) return 2'd1;
            return 2'd2;
        end
        if (bk == 2'd1) return 2'd0;
        if (bk == 2'd2) begin
            if (nd == 2'd2 && f == FREQ_1600) return 2'd1;
            if (nd == 2'd1) return 2'd0;
            return 2'd2;
        end
        if (nd == 2'd1) begin
            if (f <= FREQ_1066) return 2'd2;
            return (rc < 3'd3) ? 2'd1 : 2'd2;
        end
        if (nd == 2'd2) return 2'd2;
        return 2'd0;
    endfunction

    // Builds the expected MRS word for one request under the current settings.
    function automatic t_mrs_result predict_mrs(input t_mr_cmd cmd, input logic [2:0] cs);
        t_mrs_result r;
        logic [23:0] w;
        logic [1:0]  slot;
        logic        rank;
        logic [3:0]  cl;
        logic [2:0]  nom;
        logic [7:0]  x8;
        logic [7:0]  x4;
        logic [7:0]  peer;
        logic [7:0]  mmask;
        logic [4:0]  cwl_off;
        slot = cs[2:1];
        rank = cs[0];
        w = 24'(cs) << 21;
        case (cmd)
            MR0: begin
                cl = cl_encode(shadow.timing_word[4:0]);
                w[12]   = shadow.mode_bits[2];
                w[11:9] = wr_encode(shadow.timing_word[9:5]);
                w[8]    = 1'b1;
                w[6:4]  = cl[3:1];
                w[3]    = 1'b1;
                w[2]    = cl[0];
                w[1:0]  = shadow.mode_bits[1:0];
            end
            MR1: begin
                x8   = shadow.presence_masks[7:0];
                x4   = shadow.presence_masks[15:8];
                peer = slot[0] ? (x4 & C_EVEN_MASK) : (x4 & C_ODD_MASK);
                nom  = nominal_odt(rank);
                w = w | C_BA_MR1;
                // TDQS only for load-reduced x8 DIMMs with x4 parts elsewhere.
                if (x8[slot] && peer != 8'd0 && shadow.dimm_type == DIMM_LR) w[11] = 1'b1;
                w[9] = nom[2];
                w[6] = nom[1];
                w[2] = nom[0];
                if (shadow.dimm_type != DIMM_LR) w[1] = 1'b1;
            end
            MR2: begin
                cwl_off = shadow.timing_word[14:10] - 5'd5;
                w = w | C_BA_MR2;
                w[7]    = 1'b1;
                w[5:3]  = cwl_off[2:0];
                w[10:9] = write_odt(slot);
            end
            default: begin
                w = w | C_BA_MR3;
            end
        endcase
        r.mirrored = 1'b0;
        // Address mirroring for odd ranks of unbuffered DIMMs.
        if (shadow.dimm_type != DIMM_REG && shadow.dimm_type != DIMM_LR) begin
            mmask = shadow.presence_masks[23:16];
            if (!shadow.mode_bits[3]) mmask = (mmask & C_EVEN_MASK) << 1;
            else mmask = mmask & C_ODD_MASK;
            if (mmask[cs]) begin
                w = {w[23:20], w[18], w[19], w[17:9], w[7], w[8], w[5], w[6],
                     w[3], w[4], w[2:0]};
                r.mirrored = 1'b1;
            end
        end
        r.cmd  = cmd;
        r.cs   = cs;
        r.word = w;
        return r;
    endfunction

    // Writes one configuration register and mirrors it locally.
    task automatic write_cfg(input t_cfg_idx idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_DIMM_TYPE:       shadow.dimm_type       = val[1:0];
            CFG_BOARD_KIND:      shadow.board_kind      = val[1:0];
            CFG_DIMMS_POPULATED: shadow.dimms_populated = val[1:0];
            CFG_RANK_COUNTS:     shadow.rank_counts     = val[11:0];
            CFG_FREQ_INDEX:      shadow.freq_index      = val[4:0];
            CFG_TIMING_WORD:     shadow.timing_word     = val[14:0];
            CFG_MODE_BITS:       shadow.mode_bits       = val[3:0];
            default:             shadow.presence_masks  = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one request after a random gap, or none at full rate, and records its expected word.
    task automatic send_request(input t_mr_cmd cmd, input logic [2:0] cs);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, cs};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_mrs(cmd, cs));
    endtask

    task automatic send_random_request();
        send_request(t_mr_cmd'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    endtask

    // Stops offering requests and waits until every word has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Picks a configuration biased toward the table entries.
    task automatic random_settings();
        logic [11:0] rc;
        logic [4:0]  freq;
        logic [4:0]  tcl;
        logic [4:0]  twr;
        logic [4:0]  tcwl;
        logic [4:0]  wr_values[7];
        wr_values = '{5'd5, 5'd6, 5'd7, 5'd8, 5'd10, 5'd12, 5'd14};
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 4))
                0:       rc[3 * i +: 3] = 3'd1;
                1:       rc[3 * i +: 3] = 3'd2;
                2:       rc[3 * i +: 3] = 3'd4;
                default: rc[3 * i +: 3] = 3'($urandom_range(0, 7));
            endcase
        end
        case ($urandom_range(0, 6))
            0:       freq = FREQ_667;
            1:       freq = FREQ_800;
            2:       freq = FREQ_1066;
            3:       freq = FREQ_1333;
            4:       freq = FREQ_1600;
            default: freq = 5'($urandom_range(0, 31));
        endcase
        tcl  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(5, 16));
        twr  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : wr_values[$urandom_range(0, 6)];
        tcwl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(5, 12));
        write_cfg(CFG_DIMM_TYPE, 24'($urandom_range(0, 3)));
        write_cfg(CFG_BOARD_KIND, 24'($urandom_range(0, 3)));
        write_cfg(CFG_DIMMS_POPULATED, 24'($urandom_range(0, 3)));
        write_cfg(CFG_RANK_COUNTS, {12'd0, rc});
        write_cfg(CFG_FREQ_INDEX, {19'd0, freq});
        write_cfg(CFG_TIMING_WORD, {9'd0, tcwl, twr, tcl});
        write_cfg(CFG_MODE_BITS, 24'($urandom_range(0, 15)));
        write_cfg(CFG_PRESENCE_MASKS, 24'($urandom()));
    endtask

    // Reset settings: every register, both ends of the chip select range.
    task automatic test_reset_defaults();
        for (int c = 0; c < 4; c++) begin
            send_request(t_mr_cmd'(c), 3'd0);
            send_request(t_mr_cmd'(c), 3'd7);
        end
        wait_for_results();
    endtask

    // Field extremes and the corner cases of the tables.
    task automatic test_directed_corners();
        // All registers at their maximum; type 3 falls back to unbuffered.
        write_cfg(CFG_DIMM_TYPE, 24'd3);
        write_cfg(CFG_BOARD_KIND, 24'd3);
        write_cfg(CFG_DIMMS_POPULATED, 24'd3);
        write_cfg(CFG_RANK_COUNTS, 24'hfff);
        write_cfg(CFG_FREQ_INDEX, 24'h1f);
        write_cfg(CFG_TIMING_WORD, 24'h7fff);
        write_cfg(CFG_MODE_BITS, 24'hf);
        write_cfg(CFG_PRESENCE_MASKS, 24'hffffff);
        for (int c = 0; c < 4; c++) begin
            send_request(t_mr_cmd'(c), 3'd1);
            send_request(t_mr_cmd'(c), 3'd6);
        end
        wait_for_results();

        // Load reduced on an unsupported socket, unlisted timings, CWL below five.
        write_cfg(CFG_DIMM_TYPE, {22'd0, DIMM_LR});
        write_cfg(CFG_BOARD_KIND, 24'd0);
        write_cfg(CFG_TIMING_WORD, {9'd0, 5'd0, 5'd9, 5'd4});
        write_cfg(CFG_MODE_BITS, 24'd0);
        write_cfg(CFG_PRESENCE_MASKS, 24'hff550f);
        send_request(MR1, 3'd0);
        send_request(MR1, 3'd2);
        send_request(MR2, 3'd3);
        send_request(MR0, 3'd5);
        wait_for_results();

        // Registered DIMMs on a three-slot board.
        write_cfg(CFG_DIMM_TYPE, {22'd0, DIMM_REG});
        write_cfg(CFG_BOARD_KIND, 24'd3);
        write_cfg(CFG_DIMMS_POPULATED, 24'd2);
        write_cfg(CFG_FREQ_INDEX, {19'd0, FREQ_1333});
        send_request(MR1, 3'd0);
        send_request(MR2, 3'd4);
        send_request(MR0, 3'd7);
        wait_for_results();
    endtask

    // Both sides at full rate with mirroring on channel 0.
    task automatic test_full_rate();
        write_cfg(CFG_DIMM_TYPE, {22'd0, DIMM_UNBUF});
        write_cfg(CFG_BOARD_KIND, 24'd2);
        write_cfg(CFG_DIMMS_POPULATED, 24'd1);
        write_cfg(CFG_FREQ_INDEX, {19'd0, FREQ_800});
        write_cfg(CFG_TIMING_WORD, {9'd0, 5'd6, 5'd10, 5'd12});
        write_cfg(CFG_MODE_BITS, 24'd5);
        write_cfg(CFG_PRESENCE_MASKS, 24'h550000);
        full_rate = 1'b1;
        repeat (100) send_random_request();
        full_rate = 1'b0;
        wait_for_results();
    endtask

    // Long receiver hold-off while requests keep coming, then a paused sender.
    task automatic test_backpressure();
        random_settings();
        hold_off_cycles = 120;
        full_rate = 1'b1;
        repeat (24) send_random_request();
        full_rate = 1'b0;
        wait_for_results();
        repeat (30) send_random_request();
        wait_for_results();
    endtask

    // Random requests over many settings, starting with all registers cleared.
    task automatic test_random();
        for (int i = 0; i < 8; i++) write_cfg(t_cfg_idx'(i), 24'd0);
        repeat (PHASE_ITEMS) send_random_request();
        wait_for_results();
        for (int p = 1; p < RANDOM_PHASES; p++) begin
            random_settings();
            repeat (PHASE_ITEMS) send_random_request();
            wait_for_results();
        end
    endtask

    // Records one mismatch; only the first few are printed.
    task automatic note_mismatch(input string what, input t_mrs_result exp,
                                 input logic [23:0] exp_v, input logic [23:0] got_v);
        error_count++;
        if (error_count <= MAX_REPORTED) begin
            $display("Mismatch in %s for %s cs %0d: expected 0x%06h, got 0x%06h",
                     what, exp.cmd.name(), exp.cs, exp_v, got_v);
        end
    endtask

    // Result side: random stalls per word (none at full rate), with an optional long hold-off.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        hold_off_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = full_rate ? 0 : $urandom_range(0, 4);
            end
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Compares each returned word with the oldest expected one.
    always @(posedge i_clk) begin
        t_mrs_result exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED) begin
                    $display("Word 0x%06h returned with no request outstanding", m_axis_tdata);
                end
            end else begin
                exp = expected_results.pop_front();
                if (m_axis_tdata !== exp.word) begin
                    note_mismatch("mrs_word", exp, exp.word, m_axis_tdata);
                end
                if (m_axis_tuser !== exp.mirrored) begin
                    note_mismatch("was_mirrored", exp, 24'(exp.mirrored), 24'(m_axis_tuser));
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_DIMM_TYPE;
        i_cfg_wdata   = 24'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = MR0;
        full_rate     = 1'b0;
        error_count   = 0;
        shadow = '{dimm_type: DIMM_UNBUF, board_kind: 2'd1, dimms_populated: 2'd1,
                   rank_counts: 12'd0, freq_index: FREQ_667, timing_word: 15'd0,
                   mode_bits: 4'd0, presence_masks: 24'd0};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        test_directed_corners();
        test_full_rate();
        test_backpressure();
        test_random();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ddr3mr_pkg.sv
design/ddr3_mode_register_word_gen.sv
tb/tb_ddr3_mode_register_word_gen.sv
